/* sv/pwm_duty_cycle_capture_core_assert.svh */
// Assertion macros for the PWM duty-cycle capture core.
// Included by the top level; expects clk and rst in scope.
`ifndef PWM_DUTY_CYCLE_CAPTURE_CORE_ASSERT_SVH
`define PWM_DUTY_CYCLE_CAPTURE_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
// Same-cycle implication
`define PDC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication
`define PDC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define PDC_ASSERT_NOW(lbl, ante, cons, msg)
`define PDC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

/* sv/pdc_pkg.sv */
// Shared types and constants for the PWM duty-cycle capture core.
// No dependencies.
package pdc_pkg;

  localparam int TIMER_BITS = 16;
  localparam int STAMP_W    = 16;
  localparam int WRAP_W     = 16;
  localparam int TIME_W     = 32;
  localparam int DUTY_W     = 8;
  localparam int SCALE_W    = 7;
  localparam int PROD_W     = TIME_W + SCALE_W;
  localparam int CNT_W      = $clog2(PROD_W + 1);

  localparam logic [STAMP_W-1:0] STAMP_MASK =
    STAMP_W'((64'(1) << TIMER_BITS) - 64'(1));

  localparam logic [PROD_W-1:0] DUTY_SCALE     = PROD_W'(100);
  localparam logic [DUTY_W-1:0] DUTY_MAX       = 8'd100;
  localparam logic [DUTY_W-1:0] DUTY_NOT_READY = 8'd255;

  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_CAPTURE = 2'd1,
    OP_READ    = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    PH_WAIT_RISE0 = 2'd0,
    PH_WAIT_FALL  = 2'd1,
    PH_WAIT_RISE1 = 2'd2,
    PH_DONE       = 2'd3
  } phase_t;

  // controller -> datapath
  typedef struct packed {
    logic load_item;
    logic mul_load;
    logic div_step;
    logic res_load;
    logic out_load;
  } pdc_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic div_needed;
    logic out_free;
  } pdc_stat_t;

endpackage

/* sv/pdc_ctrl.sv */
// Controller FSM: accepts items, sequences multiply, divide and result hand-off.
// Depends on pdc_pkg.
module pdc_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  input  pdc_pkg::op_t        in_op,
  input  pdc_pkg::pdc_stat_t  stat,
  output logic                s_tready,
  output pdc_pkg::pdc_cmd_t   cmd
);
  import pdc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_DIV,
    S_SAT,
    S_EMIT
  } state_t;

  state_t             state;
  logic [CNT_W-1:0]   cnt;
  logic               accept;

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;

  // command decode
  always_comb begin
    cmd.load_item = accept;
    cmd.mul_load  = (state == S_MUL);
    cmd.div_step  = (state == S_DIV);
    cmd.res_load  = (state == S_SAT);
    cmd.out_load  = (state == S_EMIT) && stat.out_free;
  end

  // state and step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept && in_op == OP_READ) begin
            state <= stat.div_needed ? S_MUL : S_EMIT;
          end
        end
        S_MUL: begin
          cnt   <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          cnt <= cnt + 1'b1;
          if (cnt == CNT_W'(PROD_W - 1)) begin
            state <= S_SAT;
          end
        end
        S_SAT: begin
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (stat.out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* sv/pdc_dp.sv */
// Datapath: capture state, elapsed-time math, restoring divider, output register.
// Depends on pdc_pkg.
module pdc_dp (
  input  logic                       clk,
  input  logic                       rst,
  input  pdc_pkg::pdc_cmd_t          cmd,
  input  pdc_pkg::op_t               in_op,
  input  logic [pdc_pkg::STAMP_W-1:0] in_stamp,
  input  logic                       in_rising,
  input  logic                       m_tready,
  output pdc_pkg::pdc_stat_t         stat,
  output logic                       m_tvalid,
  output logic [pdc_pkg::DUTY_W-1:0] m_tdata
);
  import pdc_pkg::*;

  phase_t              phase;
  logic [STAMP_W-1:0]  start_stamp;
  logic [WRAP_W-1:0]   wrap_count;
  logic [TIME_W-1:0]   on_time;
  logic [TIME_W-1:0]   period_time;
  logic [PROD_W-1:0]   dividend;
  logic [TIME_W-1:0]   rem;
  logic [PROD_W-1:0]   quo;
  logic [DUTY_W-1:0]   res;

  logic [STAMP_W-1:0]  now;
  logic [TIME_W-1:0]   elapsed;
  logic [TIME_W:0]     rem_sh;
  logic [TIME_W:0]     rem_diff;

  // elapsed = now + wraps * 2^TIMER_BITS - start, mod 2^32
  assign now     = in_stamp & STAMP_MASK;
  assign elapsed = TIME_W'(now) + TIME_W'(48'(wrap_count) << TIMER_BITS)
                   - TIME_W'(start_stamp);

  // one restoring-division step
  assign rem_sh   = {rem, dividend[PROD_W-1]};
  assign rem_diff = rem_sh - {1'b0, period_time};

  assign stat.div_needed = (phase == PH_DONE) && (period_time != '0);
  assign stat.out_free   = !m_tvalid || m_tready;

  // capture state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_WAIT_RISE0;
      start_stamp <= '0;
      wrap_count  <= '0;
      on_time     <= '0;
      period_time <= '0;
    end else if (cmd.load_item) begin
      case (in_op)
        OP_TICK: begin
          wrap_count <= wrap_count + 1'b1;
        end
        OP_CAPTURE: begin
          if (phase == PH_WAIT_RISE0 && in_rising) begin
            start_stamp <= now;
            wrap_count  <= '0;
            phase       <= PH_WAIT_FALL;
          end else if (phase == PH_WAIT_FALL && !in_rising) begin
            on_time <= elapsed;
            phase   <= PH_WAIT_RISE1;
          end else if (phase == PH_WAIT_RISE1 && in_rising) begin
            period_time <= elapsed;
            phase       <= PH_DONE;
          end
        end
        OP_READ: begin
          if (phase == PH_DONE) begin
            phase <= PH_WAIT_RISE0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // multiply, divide, saturate
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      res <= DUTY_NOT_READY;
    end else if (cmd.res_load) begin
      res <= (quo > PROD_W'(DUTY_MAX)) ? DUTY_MAX : quo[DUTY_W-1:0];
    end
    if (cmd.mul_load) begin
      dividend <= PROD_W'(on_time) * DUTY_SCALE;
      rem      <= '0;
      quo      <= '0;
    end else if (cmd.div_step) begin
      dividend <= dividend << 1;
      if (!rem_diff[TIME_W]) begin
        rem <= rem_diff[TIME_W-1:0];
        quo <= {quo[PROD_W-2:0], 1'b1};
      end else begin
        rem <= rem_sh[TIME_W-1:0];
        quo <= {quo[PROD_W-2:0], 1'b0};
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      m_tdata <= res;
    end
  end

endmodule

/* sv/pwm_duty_cycle_capture_core.sv */
// PWM duty-cycle capture core, top level.
//
// Input channel s_*: one item per timer event. tuser[1:0] is the opcode
// (tick, capture, read), tuser[2] the edge polarity of a capture, tdata the
// 16-bit timer stamp. Ticks and captures leave the input open and give no result.
// A read gives one item on m_*: duty in percent (0..100) or 255 when no
// complete measurement exists or the period is zero.
// A read without a measurement passes through the emit state to the output register.
// A read with a measurement multiplies on-time by 100 in the multiply state,
// then runs a one-bit-per-cycle restoring divider over the 39-bit product
// and saturates the quotient to 100 before the emit state; the divider loop
// sets the read rate. One item is worked on at a time.
// The result sits in an output register; a stalled receiver holds it and the
// block takes no further item once a second result would be due.
// Synchronous active-high reset clears the capture state (waiting for the
// first rising edge), the overflow count and the output valid flag.
// Depends on pdc_pkg, pdc_ctrl, pdc_dp and the assertion macro header.
module pwm_duty_cycle_capture_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [15:0] stamp
  input  logic [2:0]  s_tuser,   // [1:0] opcode, [2] edge_rising
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata    // [7:0] duty
);
  import pdc_pkg::*;

  `include "pwm_duty_cycle_capture_core_assert.svh"

  pdc_cmd_t  cmd;
  pdc_stat_t stat;
  op_t       in_op;

  assign in_op = op_t'(s_tuser[1:0]);

  pdc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .in_op    (in_op),
    .stat     (stat),
    .s_tready (s_tready),
    .cmd      (cmd)
  );

  pdc_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .in_op     (in_op),
    .in_stamp  (s_tdata[STAMP_W-1:0]),
    .in_rising (s_tuser[2]),
    .m_tready  (m_tready),
    .stat      (stat),
    .m_tvalid  (m_tvalid),
    .m_tdata   (m_tdata)
  );

  // results are a percentage or the not-ready code
  `PDC_ASSERT_NOW(a_duty_range, m_tvalid, (m_tdata <= DUTY_MAX || m_tdata == DUTY_NOT_READY), "duty out of range")
  // a read blocks the input channel while it is worked on
  `PDC_ASSERT_NEXT(a_read_busy, s_tvalid && s_tready && s_tuser[1:0] == OP_READ, !s_tready, "input open during read")
  // a fresh result only follows a busy period
  `PDC_ASSERT_NOW(a_result_after_read, $rose(m_tvalid), $past(!s_tready), "result without read")
  // ticks and captures never occupy the block
  `PDC_ASSERT_NEXT(a_event_single_cycle, s_tvalid && s_tready && s_tuser[1:0] != OP_READ, s_tready, "event stalled input")

endmodule

/* tb/pwm_duty_cycle_capture_core_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for pwm_duty_cycle_capture_core: drives timer events on the
// input stream, predicts every duty result and compares it on the output stream.
// Depends on pdc_pkg and the core RTL.
module pwm_duty_cycle_capture_core_tb;
  import pdc_pkg::*;

  localparam int EFFECTIVE_ITEMS = 900;
  localparam int CALM_AFTER      = 760;
  localparam int LONG_HOLD       = 400;
  localparam int IDLE_LIMIT      = 4000;
  localparam int DRAIN_CYCLES    = 60;

  // Duty predictor and store of expected duty results
  class duty_tracker;
    phase_t          phase;
    logic [15:0]     start_stamp;
    logic [15:0]     wrap_count;
    logic [31:0]     on_time;
    logic [31:0]     period_time;
    logic [7:0]      exp_duty[$];
    int              errors;

    function new();
      phase       = PH_WAIT_RISE0;
      start_stamp = '0;
      wrap_count  = '0;
      on_time     = '0;
      period_time = '0;
      errors      = 0;
    endfunction

    // timer counts since the start edge, modulo 2^32
    function logic [31:0] span_since_start(logic [15:0] now);
      logic [63:0] span;
      span = 64'(now) + (64'(wrap_count) << TIMER_BITS) - 64'(start_stamp);
      return span[31:0];
    endfunction

    // Update state for an accepted item; returns 1 unless the item was ignored
    function bit note_item(op_t op, logic [15:0] stamp, logic rising);
      logic [15:0] now;
      logic [63:0] quot;
      logic [7:0]  duty;
      now = stamp & STAMP_MASK;
      case (op)
        OP_TICK: begin
          wrap_count = wrap_count + 16'd1;
          return 1'b1;
        end
        OP_CAPTURE: begin
          if (phase == PH_WAIT_RISE0 && rising) begin
            start_stamp = now;
            wrap_count  = '0;
            phase       = PH_WAIT_FALL;
          end else if (phase == PH_WAIT_FALL && !rising) begin
            on_time = span_since_start(now);
            phase   = PH_WAIT_RISE1;
          end else if (phase == PH_WAIT_RISE1 && rising) begin
            period_time = span_since_start(now);
            phase       = PH_DONE;
          end else begin
            return 1'b0;
          end
          return 1'b1;
        end
        OP_READ: begin
          duty = DUTY_NOT_READY;
          if (phase == PH_DONE) begin
            if (period_time != 0) begin
              quot = (64'(on_time) * 64'(DUTY_SCALE)) / 64'(period_time);
              duty = (quot > 64'(DUTY_MAX)) ? DUTY_MAX : quot[7:0];
            end
            phase = PH_WAIT_RISE0;
          end
          exp_duty.push_back(duty);
          return 1'b1;
        end
        default: return 1'b0;
      endcase
    endfunction

    // Compare one accepted duty result with the oldest expectation
    function void check_duty(logic [7:0] got);
      logic [7:0] want;
      if (exp_duty.size() == 0) begin
        $display("%0t: unexpected duty result, expected none, got %0d", $time, got);
        errors++;
      end else begin
        want = exp_duty.pop_front();
        if (got !== want) begin
          $display("%0t: duty mismatch, expected %0d, got %0d", $time, want, got);
          errors++;
        end
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;
  logic [2:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;

  duty_tracker sb = new();
  int          busy_items = 0;
  bit          calm = 1'b0;
  bit          long_hold_req = 1'b0;
  int          stall_left = 0;
  int          idle_cycles = 0;

  pwm_duty_cycle_capture_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #5 clk = ~clk;

  // Receiver: random stall bursts, plus one long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (long_hold_req) begin
      long_hold_req = 1'b0;
      stall_left = LONG_HOLD - 1;
      m_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 16);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Result monitor
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_duty(m_tdata);
  end

  // Watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no item moved for %0d cycles", $time, IDLE_LIMIT);
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Offer one item and wait for its handshake; optional gap first
  task automatic push_item(op_t op, logic [15:0] stamp, logic rising);
    if (!calm && $urandom_range(0, 6) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= stamp;
    s_tuser  <= {rising, 2'(op)};
    do @(posedge clk); while (!s_tready);
    if (sb.note_item(op, stamp, rising)) busy_items++;
  endtask

  task automatic push_ticks(int n);
    repeat (n) push_item(OP_TICK, 16'($urandom), 1'($urandom));
  endtask

  // Lower valid and hold until every expected duty has arrived
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (sb.exp_duty.size() != 0);
  endtask

  function automatic int pick_ticks();
    if ($urandom_range(0, 7) == 0) return $urandom_range(0, 300);
    return $urandom_range(0, 3);
  endfunction

  // One well-formed measurement with random stamps, a little noise, then usually a read
  task automatic random_cycle();
    if ($urandom_range(0, 7) == 0) push_item(OP_READ, 16'($urandom), 1'($urandom));
    if ($urandom_range(0, 5) == 0) push_item(OP_CAPTURE, 16'($urandom), 1'b0);
    push_item(OP_CAPTURE, 16'($urandom), 1'b1);
    push_ticks(pick_ticks());
    if ($urandom_range(0, 5) == 0) push_item(OP_CAPTURE, 16'($urandom), 1'b1);
    push_item(OP_CAPTURE, 16'($urandom), 1'b0);
    push_ticks(pick_ticks());
    if ($urandom_range(0, 5) == 0) push_item(OP_CAPTURE, 16'($urandom), 1'b0);
    push_item(OP_CAPTURE, 16'($urandom), 1'b1);
    if ($urandom_range(0, 4) == 0) push_item(OP_CAPTURE, 16'($urandom), 1'($urandom));
    if ($urandom_range(0, 4) == 0) push_ticks(1);
    if ($urandom_range(0, 9) != 0) push_item(OP_READ, 16'($urandom), 1'($urandom));
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed: not ready, unused opcode, wrong edges, normal measurement
    push_item(OP_READ, 16'h0000, 1'b0);
    push_item(OP_NONE, 16'hFFFF, 1'b1);
    push_item(OP_CAPTURE, 16'h0000, 1'b0);
    push_item(OP_CAPTURE, 16'hFFFF, 1'b1);
    push_item(OP_CAPTURE, 16'h0000, 1'b1);
    push_item(OP_TICK, 16'hFFFF, 1'b0);
    push_item(OP_READ, 16'hFFFF, 1'b1);
    push_item(OP_CAPTURE, 16'h7FFF, 1'b0);
    push_item(OP_TICK, 16'h0000, 1'b1);
    push_item(OP_CAPTURE, 16'hFFFF, 1'b1);
    // captures ignored once complete, ticks still counted
    push_item(OP_CAPTURE, 16'h0000, 1'b0);
    push_item(OP_TICK, 16'h5555, 1'b0);
    push_item(OP_READ, 16'hAAAA, 1'b0);
    // zero period still rearms
    push_item(OP_CAPTURE, 16'h1234, 1'b1);
    push_item(OP_CAPTURE, 16'h1234, 1'b0);
    push_item(OP_CAPTURE, 16'h1234, 1'b1);
    push_item(OP_READ, 16'h0000, 1'b0);
    // on-time above period saturates
    push_item(OP_CAPTURE, 16'h0000, 1'b1);
    push_item(OP_CAPTURE, 16'hFFFF, 1'b0);
    push_item(OP_CAPTURE, 16'h0001, 1'b1);
    push_item(OP_READ, 16'hFFFF, 1'b1);
    // zero on-time
    push_item(OP_CAPTURE, 16'h8000, 1'b1);
    push_item(OP_CAPTURE, 16'h8000, 1'b0);
    push_item(OP_TICK, 16'h0000, 1'b0);
    push_item(OP_CAPTURE, 16'h8000, 1'b1);
    push_item(OP_READ, 16'h0000, 1'b0);
    wait_drained();

    // Long receiver hold-off while reads keep coming
    long_hold_req = 1'b1;
    repeat (6) random_cycle();
    wait_drained();

    // Random part: mostly full measurements, some noise items
    while (busy_items < EFFECTIVE_ITEMS) begin
      if ($urandom_range(0, 4) == 0)
        push_item(op_t'(2'($urandom_range(0, 3))), 16'($urandom), 1'($urandom));
      else
        random_cycle();
      if (busy_items > EFFECTIVE_ITEMS / 2 && busy_items < EFFECTIVE_ITEMS / 2 + 20)
        wait_drained();
      calm = (busy_items > CALM_AFTER);
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.exp_duty.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end
endmodule
